// File: design/tspnn_pkg.sv
// Shared constants for the nearest-neighbour / 2-opt tour core.
`default_nettype none
package tspnn_pkg;
   localparam int DEF_MAX_NODES  = 64;
   localparam int DEF_COORD_BITS = 16;
   localparam int DEF_FRAC_BITS  = 8;

   localparam int NODE_W     = 6;
   localparam int COST_W     = 31;
   localparam int NCOUNT_W   = 7;
   localparam int MARGIN_W   = 16;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 16;

   localparam logic [COST_W-1:0]    COST_MAX     = {COST_W{1'b1}};
   localparam logic [NCOUNT_W-1:0]  NCOUNT_RESET = 7'd64;
   localparam logic [NCOUNT_W-1:0]  NCOUNT_MIN   = 7'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_NODE_COUNT     = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMPROVE_MARGIN = 4'd1;
endpackage
`default_nettype wire

// File: design/tspnn_isqrt.sv
// Iterative integer square root, one root bit per cycle.
`default_nettype none
module tspnn_isqrt #(
   parameter int SQ_W = 49
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      go,
   input  logic [SQ_W-1:0]           value,
   output logic                      done,
   output logic [(SQ_W+1)/2-1:0]     root
);
   localparam int RW = (SQ_W + 1) / 2;
   localparam int VW = 2 * RW;
   localparam int SW = $clog2(RW + 1);

   logic [VW-1:0]   v_ff, v_in;
   logic [RW+2:0]   rem_ff, rem_in, trial, sub;
   logic [RW-1:0]   root_ff, root_in;
   logic [SW-1:0]   cnt_ff, cnt_in;
   logic            run_ff, run_in;
   logic            done_ff, done_in;

   always_comb begin
      trial   = {rem_ff[RW:0], v_ff[VW-1 -: 2]};
      sub     = {1'b0, root_ff, 2'b01};
      v_in    = v_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (go) begin
         v_in    = VW'(value);
         rem_in  = '0;
         root_in = '0;
         cnt_in  = SW'(RW);
         run_in  = 1'b1;
      end else if (run_ff) begin
         v_in = v_ff << 2;
         if (trial >= sub) begin
            rem_in  = trial - sub;
            root_in = {root_ff[RW-2:0], 1'b1};
         end else begin
            rem_in  = trial;
            root_in = {root_ff[RW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - SW'(1);
         if (cnt_ff == SW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      v_ff    <= v_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
   end

   assign done = done_ff;
   assign root = root_ff;
endmodule
`default_nettype wire

// File: design/tsp_nearest_neighbor_two_opt_core.sv
// Travelling-salesman core: nearest-neighbour tours from every start, 2-opt, best tour out.
// Coordinates load one per cycle while busy is low; the item that completes the node count
// starts the solve and raises busy until the last tour node has been sent. The solve fills
// the n*n distance store through one shared multiplier and a bit-serial square root, then
// builds a nearest-neighbour tour from each start and costs it, then runs 2-opt passes,
// reversing the segment of each candidate that gains more than the improve margin and
// costing the tour again; each new best tour is copied into the best-tour store. Results
// then follow one tour node at a time, each with rsp_valid high for one cycle; the receiver
// cannot stall them. No clearing pass is needed after reset.
`default_nettype none
module tsp_nearest_neighbor_two_opt_core
   import tspnn_pkg::*;
#(
   parameter int MAX_NODES  = DEF_MAX_NODES,
   parameter int COORD_BITS = DEF_COORD_BITS,
   parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [COORD_BITS-1:0] req_x_coord,
   input  logic [COORD_BITS-1:0] req_y_coord,
   output logic                  rsp_valid,
   output logic [NODE_W-1:0]     rsp_tour_node,
   output logic [COST_W-1:0]     rsp_tour_cost,
   output logic                  rsp_last_of_tour,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);
   localparam int NW       = $clog2(MAX_NODES);
   localparam int CW       = $clog2(MAX_NODES + 1);
   localparam int SQ0_W    = 2 * COORD_BITS + 1;
   localparam int SQ_W     = SQ0_W + 2 * FRAC_BITS;
   localparam int DW       = (SQ_W + 1) / 2;
   localparam int DLW      = DW + 3;
   localparam int CMPW     = (DLW > MARGIN_W + 1 ? DLW : MARGIN_W + 1) + 1;
   localparam int DM_DEPTH = 1 << (2 * NW);

   typedef enum logic [5:0] {
      S_IDLE, S_D0, S_D1, S_D2, S_D3, S_D4, S_D5, S_SQ,
      S_NI, S_NN_RD, S_NN_CMP,
      S_CA, S_CB, S_CC, S_OFF, S_CP0, S_CP1,
      S_TI, S_T0, S_T1, S_T2, S_T3, S_T4, S_T5, S_T6, S_T7, S_T8, S_T9, S_ADV,
      S_R0, S_R1, S_R2, S_R3,
      S_O0, S_O1
   } state_type;

   state_type state_ff, state_in;

   logic [NW-1:0]        nl_ff, nl_in;
   logic [NCOUNT_W-1:0]  nc_ff;
   logic [MARGIN_W-1:0]  margin_ff;
   logic [CW-1:0]        i_ff, i_in, j_ff, j_in, k_ff, k_in, pos_ff, pos_in;
   logic [CW-1:0]        st_ff, st_in, l_ff, l_in, r_ff, r_in;
   logic [NW-1:0]        cur_ff, cur_in, next_ff, next_in, prev_ff, prev_in;
   logic [NW-1:0]        ti_ff, ti_in, ti1_ff, ti1_in, tj_ff, tj_in, tnj_ff, tnj_in;
   logic [NW-1:0]        tmp_ff, tmp_in;
   logic [DW-1:0]        md_ff, md_in;
   logic                 found_ff, found_in, have_ff, have_in;
   logic                 improved_ff, improved_in, ret_ff, ret_in;
   logic [MAX_NODES-1:0] vis_ff, vis_in;
   logic [COST_W-1:0]    acc_ff, acc_in, best_ff, best_in;
   logic signed [DLW-1:0] delta_ff, delta_in;
   logic [COORD_BITS-1:0] xa_ff, xa_in, ya_ff, ya_in, dx_ff, dx_in, dy_ff, dy_in;
   logic [SQ0_W-1:0]     sq_ff, sq_in;
   logic                 rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in;
   logic [NW-1:0]        rsp_node_ff, rsp_node_in;

   logic [COORD_BITS-1:0] x_mem [MAX_NODES];
   logic [COORD_BITS-1:0] y_mem [MAX_NODES];
   logic [DW-1:0]         dm_mem [DM_DEPTH];
   logic [NW-1:0]         wt_mem [MAX_NODES];
   logic [NW-1:0]         bt_mem [MAX_NODES];
   logic [COORD_BITS-1:0] xr_ff, yr_ff;
   logic [DW-1:0]         dr_ff;
   logic [NW-1:0]         wtr_ff, btr_ff;

   logic                  accept;
   logic [NW-1:0]         xy_ra, wt_ra, wt_wa, bt_ra, bt_wa;
   logic [2*NW-1:0]       dm_ra;
   logic                  wt_we, bt_we, dm_we;
   logic [NW-1:0]         wt_wd, bt_wd;
   logic [NCOUNT_W-1:0]   n7;
   logic [CW-1:0]         n, j_p1, nj, p_p1;
   logic [COORD_BITS-1:0] mop;
   logic [2*COORD_BITS-1:0] prod;
   logic                  sq_go, sq_done;
   logic [DW-1:0]         sq_root;
   logic [COST_W:0]       csum;
   logic signed [DLW-1:0] dr_ext;
   logic signed [CMPW-1:0] mv_sum;
   logic                  take;

   assign accept    = start && (state_ff == S_IDLE);
   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_tour_node    = NODE_W'(rsp_node_ff);
   assign rsp_tour_cost    = best_ff;
   assign rsp_last_of_tour = rsp_last_ff;

   always_comb begin
      if (nc_ff < NCOUNT_MIN) begin
         n7 = NCOUNT_MIN;
      end else if (nc_ff > NCOUNT_W'(MAX_NODES)) begin
         n7 = NCOUNT_W'(MAX_NODES);
      end else begin
         n7 = nc_ff;
      end
   end
   assign n      = CW'(n7);
   assign j_p1   = j_ff + CW'(1);
   assign nj     = (j_p1 == n) ? '0 : j_p1;
   assign p_p1   = CW'(nl_ff) + CW'(1);
   assign mop    = (state_ff == S_D3) ? dx_ff : dy_ff;
   assign prod   = mop * mop;
   assign csum   = {1'b0, acc_ff} + (COST_W + 1)'(dr_ff);
   assign dr_ext = $signed(DLW'(dr_ff));
   assign mv_sum = CMPW'(delta_ff) + $signed(CMPW'(margin_ff));
   assign take   = !vis_ff[j_ff[NW-1:0]] && (!found_ff || dr_ff < md_ff);

   tspnn_isqrt #(
      .SQ_W (SQ_W)
   ) u_isqrt (
      .clock (clock),
      .reset (reset),
      .go    (sq_go),
      .value (SQ_W'(sq_ff) << (2 * FRAC_BITS)),
      .done  (sq_done),
      .root  (sq_root)
   );

   always_comb begin
      state_in = state_ff;
      nl_in = nl_ff;
      i_in = i_ff; j_in = j_ff; k_in = k_ff; pos_in = pos_ff;
      st_in = st_ff; l_in = l_ff; r_in = r_ff;
      cur_in = cur_ff; next_in = next_ff; prev_in = prev_ff;
      ti_in = ti_ff; ti1_in = ti1_ff; tj_in = tj_ff; tnj_in = tnj_ff; tmp_in = tmp_ff;
      md_in = md_ff; found_in = found_ff; have_in = have_ff;
      improved_in = improved_ff; ret_in = ret_ff; vis_in = vis_ff;
      acc_in = acc_ff; best_in = best_ff; delta_in = delta_ff;
      xa_in = xa_ff; ya_in = ya_ff; dx_in = dx_ff; dy_in = dy_ff; sq_in = sq_ff;
      rsp_valid_in = 1'b0; rsp_last_in = rsp_last_ff; rsp_node_in = rsp_node_ff;
      xy_ra = i_ff[NW-1:0];
      wt_ra = i_ff[NW-1:0];
      bt_ra = k_ff[NW-1:0];
      dm_ra = {cur_ff, j_ff[NW-1:0]};
      wt_we = 1'b0; wt_wa = '0; wt_wd = '0;
      bt_we = 1'b0; bt_wa = k_ff[NW-1:0]; bt_wd = wtr_ff;
      dm_we = 1'b0;
      sq_go = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (p_p1 >= n) begin
                  nl_in    = '0;
                  i_in     = '0;
                  j_in     = '0;
                  st_in    = '0;
                  have_in  = 1'b0;
                  best_in  = COST_MAX;
                  state_in = S_D0;
               end else begin
                  nl_in = p_p1[NW-1:0];
               end
            end
         end
         S_D0: state_in = S_D1;
         S_D1: begin
            xy_ra    = j_ff[NW-1:0];
            xa_in    = xr_ff;
            ya_in    = yr_ff;
            state_in = S_D2;
         end
         S_D2: begin
            dx_in    = (xa_ff > xr_ff) ? xa_ff - xr_ff : xr_ff - xa_ff;
            dy_in    = (ya_ff > yr_ff) ? ya_ff - yr_ff : yr_ff - ya_ff;
            state_in = S_D3;
         end
         S_D3: begin
            sq_in    = SQ0_W'(prod);
            state_in = S_D4;
         end
         S_D4: begin
            sq_in    = sq_ff + SQ0_W'(prod);
            state_in = S_D5;
         end
         S_D5: begin
            sq_go    = 1'b1;
            state_in = S_SQ;
         end
         S_SQ: begin
            if (sq_done) begin
               dm_we = 1'b1;
               if (j_p1 < n) begin
                  j_in     = j_p1;
                  state_in = S_D0;
               end else if (i_ff + CW'(1) < n) begin
                  j_in     = '0;
                  i_in     = i_ff + CW'(1);
                  state_in = S_D0;
               end else begin
                  state_in = S_NI;
               end
            end
         end
         S_NI: begin
            wt_we    = 1'b1;
            wt_wa    = '0;
            wt_wd    = st_ff[NW-1:0];
            vis_in   = MAX_NODES'(1) << st_ff[NW-1:0];
            cur_in   = st_ff[NW-1:0];
            pos_in   = CW'(1);
            j_in     = '0;
            found_in = 1'b0;
            state_in = S_NN_RD;
         end
         S_NN_RD: state_in = S_NN_CMP;
         S_NN_CMP: begin
            if (take) begin
               md_in    = dr_ff;
               next_in  = j_ff[NW-1:0];
               found_in = 1'b1;
            end
            if (j_p1 < n) begin
               j_in     = j_p1;
               state_in = S_NN_RD;
            end else begin
               wt_we    = 1'b1;
               wt_wa    = pos_ff[NW-1:0];
               wt_wd    = take ? j_ff[NW-1:0] : next_ff;
               vis_in   = vis_ff | (MAX_NODES'(1) << wt_wd);
               cur_in   = wt_wd;
               found_in = 1'b0;
               j_in     = '0;
               if (pos_ff + CW'(1) < n) begin
                  pos_in   = pos_ff + CW'(1);
                  state_in = S_NN_RD;
               end else begin
                  k_in     = '0;
                  acc_in   = '0;
                  ret_in   = 1'b0;
                  state_in = S_CA;
               end
            end
         end
         S_CA: begin
            wt_ra    = (k_ff == n) ? '0 : k_ff[NW-1:0];
            state_in = S_CB;
         end
         S_CB: begin
            prev_in = wtr_ff;
            if (k_ff == '0) begin
               k_in     = CW'(1);
               state_in = S_CA;
            end else begin
               dm_ra    = {prev_ff, wtr_ff};
               state_in = S_CC;
            end
         end
         S_CC: begin
            acc_in = (csum > (COST_W + 1)'(COST_MAX)) ? COST_MAX : csum[COST_W-1:0];
            if (k_ff == n) begin
               state_in = S_OFF;
            end else begin
               k_in     = k_ff + CW'(1);
               state_in = S_CA;
            end
         end
         S_OFF: begin
            if (!have_ff || acc_ff < best_ff) begin
               best_in  = acc_ff;
               have_in  = 1'b1;
               k_in     = '0;
               state_in = S_CP0;
            end else begin
               state_in = ret_ff ? S_ADV : S_TI;
            end
         end
         S_CP0: begin
            wt_ra    = k_ff[NW-1:0];
            state_in = S_CP1;
         end
         S_CP1: begin
            bt_we = 1'b1;
            if (k_ff + CW'(1) < n) begin
               k_in     = k_ff + CW'(1);
               state_in = S_CP0;
            end else begin
               state_in = ret_ff ? S_ADV : S_TI;
            end
         end
         S_TI: begin
            i_in        = '0;
            j_in        = CW'(1);
            improved_in = 1'b0;
            state_in    = S_T0;
         end
         S_T0: state_in = S_T1;
         S_T1: begin
            wt_ra    = i_ff[NW-1:0] + NW'(1);
            ti_in    = wtr_ff;
            state_in = S_T2;
         end
         S_T2: begin
            wt_ra    = j_ff[NW-1:0];
            ti1_in   = wtr_ff;
            state_in = S_T3;
         end
         S_T3: begin
            wt_ra    = nj[NW-1:0];
            tj_in    = wtr_ff;
            state_in = S_T4;
         end
         S_T4: begin
            tnj_in   = wtr_ff;
            dm_ra    = {ti_ff, tj_ff};
            state_in = S_T5;
         end
         S_T5: begin
            dm_ra    = {ti1_ff, tnj_ff};
            delta_in = dr_ext;
            state_in = S_T6;
         end
         S_T6: begin
            dm_ra    = {ti_ff, ti1_ff};
            delta_in = delta_ff + dr_ext;
            state_in = S_T7;
         end
         S_T7: begin
            dm_ra    = {tj_ff, tnj_ff};
            delta_in = delta_ff - dr_ext;
            state_in = S_T8;
         end
         S_T8: begin
            delta_in = delta_ff - dr_ext;
            state_in = S_T9;
         end
         S_T9: begin
            if (mv_sum[CMPW-1]) begin
               l_in     = i_ff + CW'(1);
               r_in     = j_ff;
               state_in = S_R0;
            end else begin
               state_in = S_ADV;
            end
         end
         S_ADV: begin
            if (j_p1 < n) begin
               j_in     = j_p1;
               state_in = S_T0;
            end else if (i_ff + CW'(2) < n) begin
               i_in     = i_ff + CW'(1);
               j_in     = i_ff + CW'(2);
               state_in = S_T0;
            end else if (improved_ff) begin
               state_in = S_TI;
            end else if (st_ff + CW'(1) < n) begin
               st_in    = st_ff + CW'(1);
               state_in = S_NI;
            end else begin
               k_in     = '0;
               state_in = S_O0;
            end
         end
         S_R0: begin
            wt_ra    = l_ff[NW-1:0];
            state_in = S_R1;
         end
         S_R1: begin
            wt_ra    = r_ff[NW-1:0];
            tmp_in   = wtr_ff;
            state_in = S_R2;
         end
         S_R2: begin
            wt_we    = 1'b1;
            wt_wa    = l_ff[NW-1:0];
            wt_wd    = wtr_ff;
            state_in = S_R3;
         end
         S_R3: begin
            wt_we = 1'b1;
            wt_wa = r_ff[NW-1:0];
            wt_wd = tmp_ff;
            l_in  = l_ff + CW'(1);
            r_in  = r_ff - CW'(1);
            if (l_ff + CW'(2) < r_ff) begin
               state_in = S_R0;
            end else begin
               improved_in = 1'b1;
               ret_in      = 1'b1;
               k_in        = '0;
               acc_in      = '0;
               state_in    = S_CA;
            end
         end
         S_O0: state_in = S_O1;
         S_O1: begin
            rsp_valid_in = 1'b1;
            rsp_node_in  = btr_ff;
            rsp_last_in  = (k_ff + CW'(1) == n);
            if (k_ff + CW'(1) == n) begin
               state_in = S_IDLE;
            end else begin
               k_in     = k_ff + CW'(1);
               state_in = S_O0;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         nl_ff        <= '0;
         nc_ff        <= NCOUNT_RESET;
         margin_ff    <= '0;
         vis_ff       <= '0;
         best_ff      <= COST_MAX;
         have_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         nl_ff        <= nl_in;
         vis_ff       <= vis_in;
         best_ff      <= best_in;
         have_ff      <= have_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_NODE_COUNT:     nc_ff     <= csr_wdata[NCOUNT_W-1:0];
               CSR_IMPROVE_MARGIN: margin_ff <= csr_wdata[MARGIN_W-1:0];
               default: ;
            endcase
         end
      end
      i_ff <= i_in; j_ff <= j_in; k_ff <= k_in; pos_ff <= pos_in;
      st_ff <= st_in; l_ff <= l_in; r_ff <= r_in;
      cur_ff <= cur_in; next_ff <= next_in; prev_ff <= prev_in;
      ti_ff <= ti_in; ti1_ff <= ti1_in; tj_ff <= tj_in; tnj_ff <= tnj_in; tmp_ff <= tmp_in;
      md_ff <= md_in; found_ff <= found_in;
      improved_ff <= improved_in; ret_ff <= ret_in;
      acc_ff <= acc_in; delta_ff <= delta_in;
      xa_ff <= xa_in; ya_ff <= ya_in; dx_ff <= dx_in; dy_ff <= dy_in; sq_ff <= sq_in;
      rsp_last_ff <= rsp_last_in; rsp_node_ff <= rsp_node_in;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         x_mem[nl_ff] <= req_x_coord;
         y_mem[nl_ff] <= req_y_coord;
      end
      xr_ff <= x_mem[xy_ra];
      yr_ff <= y_mem[xy_ra];
   end

   always_ff @(posedge clock) begin
      if (dm_we) begin
         dm_mem[{i_ff[NW-1:0], j_ff[NW-1:0]}] <= sq_root;
      end
      dr_ff <= dm_mem[dm_ra];
   end

   always_ff @(posedge clock) begin
      if (wt_we) begin
         wt_mem[wt_wa] <= wt_wd;
      end
      wtr_ff <= wt_mem[wt_ra];
   end

   always_ff @(posedge clock) begin
      if (bt_we) begin
         bt_mem[bt_wa] <= bt_wd;
      end
      btr_ff <= bt_mem[bt_ra];
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_of_tour |=> !rsp_valid)
      else $error("result after last tour node");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_of_tour |-> busy)
      else $error("tour output ended early");
   assert property (@(posedge clock) disable iff (reset)
      sq_done |-> state_ff == S_SQ)
      else $error("square root finished outside distance fill");
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_NN_RD |-> $countones(vis_ff) == int'(pos_ff))
      else $error("visited mask out of step with tour position");
endmodule
`default_nettype wire

// File: tb/sv/tb_tsp_nearest_neighbor_two_opt_core.sv
// Self-checking testbench for the nearest-neighbour / 2-opt tour core.
`default_nettype none
module tb_tsp_nearest_neighbor_two_opt_core;
   import tspnn_pkg::*;

   localparam int MAXN = DEF_MAX_NODES;
   localparam int IDLE_LIMIT = 600000;
   localparam int DRAIN_CYCLES = 20;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 4'd9;

   typedef struct packed {
      logic [NODE_W-1:0] node;
      logic [COST_W-1:0] cost;
      logic              last;
   } tour_step_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [DEF_COORD_BITS-1:0] req_x_coord = '0;
   logic [DEF_COORD_BITS-1:0] req_y_coord = '0;
   logic rsp_valid;
   logic [NODE_W-1:0] rsp_tour_node;
   logic [COST_W-1:0] rsp_tour_cost;
   logic rsp_last_of_tour;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   tsp_nearest_neighbor_two_opt_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_x_coord(req_x_coord), .req_y_coord(req_y_coord),
      .rsp_valid(rsp_valid), .rsp_tour_node(rsp_tour_node),
      .rsp_tour_cost(rsp_tour_cost), .rsp_last_of_tour(rsp_last_of_tour),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predictor state
   logic [NCOUNT_W-1:0] cfg_nodes = NCOUNT_RESET;
   logic [MARGIN_W-1:0] cfg_margin = '0;
   logic [15:0] pos_x [MAXN];
   logic [15:0] pos_y [MAXN];
   longint unsigned dist_tab [MAXN][MAXN];
   int route [MAXN];
   int best_route [MAXN];
   logic [COST_W-1:0] best_len;
   bit have_best;
   int loaded = 0;
   tour_step_type tour_expect [$];

   int errors = 0;
   int items_sent = 0;
   bit idling_on = 1'b1;
   int quiet_cycles = 0;

   function automatic int active_nodes();
      if (cfg_nodes < NCOUNT_MIN) return NCOUNT_MIN;
      if (cfg_nodes > MAXN) return MAXN;
      return cfg_nodes;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic void offer_route(int n);
      longint unsigned s;
      logic [COST_W-1:0] c;
      s = 0;
      for (int k = 0; k < n; k++) s += dist_tab[route[k]][route[(k + 1 == n) ? 0 : k + 1]];
      c = (s > COST_MAX) ? COST_MAX : s[COST_W-1:0];
      if (!have_best || c < best_len) begin
         best_len = c;
         for (int k = 0; k < n; k++) best_route[k] = route[k];
         have_best = 1'b1;
      end
   endfunction

   function automatic void solve_tours(int n);
      longint unsigned dx, dy, md;
      longint delta;
      int cur, nxt, nj, l, r, t;
      bit found, improved;
      logic [MAXN-1:0] seen;
      for (int a = 0; a < n; a++)
         for (int b = 0; b < n; b++) begin
            dx = (pos_x[a] > pos_x[b]) ? pos_x[a] - pos_x[b] : pos_x[b] - pos_x[a];
            dy = (pos_y[a] > pos_y[b]) ? pos_y[a] - pos_y[b] : pos_y[b] - pos_y[a];
            dist_tab[a][b] = int_sqrt((dx * dx + dy * dy) << (2 * DEF_FRAC_BITS));
         end
      have_best = 1'b0;
      best_len = COST_MAX;
      for (int s = 0; s < n; s++) begin
         cur = s;
         seen = '0;
         seen[cur] = 1'b1;
         route[0] = cur;
         for (int p = 1; p < n; p++) begin
            nxt = 0;
            found = 1'b0;
            md = 0;
            for (int j = 0; j < n; j++) begin
               if (!seen[j] && (!found || dist_tab[cur][j] < md)) begin
                  md = dist_tab[cur][j];
                  nxt = j;
                  found = 1'b1;
               end
            end
            route[p] = nxt;
            seen[nxt] = 1'b1;
            cur = nxt;
         end
         offer_route(n);
         improved = 1'b1;
         while (improved) begin
            improved = 1'b0;
            for (int i = 0; i + 1 < n; i++)
               for (int j = i + 1; j < n; j++) begin
                  nj = (j + 1 == n) ? 0 : j + 1;
                  delta = longint'(dist_tab[route[i]][route[j]])
                        + longint'(dist_tab[route[i + 1]][route[nj]])
                        - longint'(dist_tab[route[i]][route[i + 1]])
                        - longint'(dist_tab[route[j]][route[nj]]);
                  if (delta < -longint'(cfg_margin)) begin
                     l = i + 1;
                     r = j;
                     while (l < r) begin
                        t = route[l];
                        route[l] = route[r];
                        route[r] = t;
                        l++;
                        r--;
                     end
                     improved = 1'b1;
                     offer_route(n);
                  end
               end
         end
      end
   endfunction

   function automatic void load_node(logic [15:0] x, logic [15:0] y);
      int p, n;
      tour_step_type e;
      n = active_nodes();
      p = loaded % MAXN;
      pos_x[p] = x;
      pos_y[p] = y;
      loaded = p + 1;
      if (loaded >= n) begin
         solve_tours(n);
         for (int k = 0; k < n; k++) begin
            e.node = best_route[k][NODE_W-1:0];
            e.cost = best_len;
            e.last = (k + 1 == n);
            tour_expect.push_back(e);
         end
         loaded = 0;
      end
   endfunction

   task automatic send_node(input logic [15:0] x, input logic [15:0] y);
      bit taken;
      if (idling_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      start <= 1'b1;
      req_x_coord <= x;
      req_y_coord <= y;
      do begin
         @(negedge clock);
         taken = !busy;
         @(posedge clock);
      end while (!taken);
      items_sent++;
      load_node(x, y);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      bit taken;
      start <= 1'b0;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do begin
         @(negedge clock);
         taken = csr_ready;
         @(posedge clock);
      end while (!taken);
      if (idx == CSR_NODE_COUNT) cfg_nodes = val[NCOUNT_W-1:0];
      else if (idx == CSR_IMPROVE_MARGIN) cfg_margin = val[MARGIN_W-1:0];
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_quiet();
      start <= 1'b0;
      while (tour_expect.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // result checker and watchdog
   always @(negedge clock) begin
      tour_step_type e;
      if (!reset) begin
         if (rsp_valid) begin
            if (tour_expect.size() == 0) begin
               $display("%0t: unexpected result node=%0d cost=%0d last=%0d", $time,
                        rsp_tour_node, rsp_tour_cost, rsp_last_of_tour);
               errors++;
            end else begin
               e = tour_expect.pop_front();
               if (rsp_tour_node !== e.node) begin
                  $display("%0t: tour_node expected %0d actual %0d", $time, e.node,
                           rsp_tour_node);
                  errors++;
               end
               if (rsp_tour_cost !== e.cost) begin
                  $display("%0t: tour_cost expected %0d actual %0d", $time, e.cost,
                           rsp_tour_cost);
                  errors++;
               end
               if (rsp_last_of_tour !== e.last) begin
                  $display("%0t: last_of_tour expected %0d actual %0d", $time, e.last,
                           rsp_last_of_tour);
                  errors++;
               end
            end
         end
         if ((start && !busy) || rsp_valid || (csr_valid && csr_ready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles > IDLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   task automatic test_corners();
      write_reg(CSR_NODE_COUNT, 16'd3);
      write_reg(CSR_IMPROVE_MARGIN, 16'd0);
      send_node(16'h0000, 16'h0000);
      send_node(16'hFFFF, 16'hFFFF);
      send_node(16'h0000, 16'hFFFF);
      send_node(16'hFFFF, 16'h0000);
      send_node(16'h0000, 16'h0000);
      send_node(16'h0000, 16'h0000);
      wait_quiet();
   endtask

   task automatic test_clamp_low();
      write_reg(CSR_NODE_COUNT, 16'd0);
      send_node(16'd5, 16'd1);
      send_node(16'd2, 16'd9);
      send_node(16'd7, 16'd7);
      wait_quiet();
      write_reg(CSR_NODE_COUNT, 16'd2);
      send_node(16'd1, 16'd1);
      send_node(16'd1, 16'd1);
      send_node(16'd3, 16'd0);
      wait_quiet();
   endtask

   task automatic test_ties_and_crossing();
      write_reg(CSR_NODE_COUNT, 16'd4);
      send_node(16'd0, 16'd0);
      send_node(16'd10, 16'd10);
      send_node(16'd10, 16'd0);
      send_node(16'd0, 16'd10);
      wait_quiet();
   endtask

   // count raised to the clamp and then lowered below what is already loaded
   task automatic test_count_lowered();
      write_reg(CSR_NODE_COUNT, 16'd127);
      write_reg(CSR_UNMAPPED, 16'hFFFF);
      send_node(16'd100, 16'd3);
      send_node(16'd3, 16'd200);
      send_node(16'd50, 16'd50);
      write_reg(CSR_NODE_COUNT, 16'd64);
      send_node(16'd250, 16'd1);
      send_node(16'd9, 16'd9);
      write_reg(CSR_NODE_COUNT, 16'd4);
      send_node(16'd77, 16'd123);
      wait_quiet();
   endtask

   task automatic test_margin_max();
      write_reg(CSR_IMPROVE_MARGIN, 16'hFFFF);
      write_reg(CSR_NODE_COUNT, 16'd7);
      for (int k = 0; k < 7; k++) send_node(16'($urandom), 16'($urandom));
      wait_quiet();
      write_reg(CSR_IMPROVE_MARGIN, 16'd0);
      write_reg(CSR_NODE_COUNT, 16'd12);
      for (int k = 0; k < 12; k++)
         send_node(16'($urandom_range(0, 40)), 16'($urandom_range(0, 40)));
      wait_quiet();
   endtask

   task automatic test_random_instances();
      int target, spread;
      target = items_sent + 70;
      while (items_sent < target) begin
         idling_on = (target - items_sent) > 25;
         wait_quiet();
         if ($urandom_range(0, 9) == 0) write_reg(CSR_NODE_COUNT, 16'($urandom_range(11, 13)));
         else write_reg(CSR_NODE_COUNT, 16'($urandom_range(3, 9)));
         case ($urandom_range(0, 3))
            0: write_reg(CSR_IMPROVE_MARGIN, 16'd0);
            1: write_reg(CSR_IMPROVE_MARGIN, 16'($urandom_range(1, 600)));
            2: write_reg(CSR_IMPROVE_MARGIN, 16'($urandom));
            default: ;
         endcase
         spread = ($urandom_range(0, 2) == 0) ? 7 : 65535;
         if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 2)) send_node(16'($urandom_range(0, spread)),
                                                   16'($urandom_range(0, spread)));
            wait_quiet();
            write_reg(CSR_NODE_COUNT, 16'($urandom_range(0, 4)));
         end
         do send_node(16'($urandom_range(0, spread)), 16'($urandom_range(0, spread)));
         while (loaded != 0);
      end
      idling_on = 1'b0;
      wait_quiet();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_corners();
      test_clamp_low();
      test_ties_and_crossing();
      test_count_lowered();
      test_margin_max();
      test_random_instances();
      if (errors == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end
endmodule
`default_nettype wire

// File: tsp_nearest_neighbor_two_opt_core.f
design/tspnn_pkg.sv
design/tspnn_isqrt.sv
design/tsp_nearest_neighbor_two_opt_core.sv
tb/sv/tb_tsp_nearest_neighbor_two_opt_core.sv
